// ----- hw/rtl/qssud_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qssud_pkg: shared types and helpers of the query string splitter
// Result and bundle types, character codes, part modes and the per-byte
// parse functions used by the front end.
// ----------------------------------------------------------------------------
package qssud_pkg;

   // Character codes
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LC_A    = 8'h61;
   localparam logic [7:0] CH_LC_F    = 8'h66;
   localparam logic [7:0] CH_UC_A    = 8'h41;
   localparam logic [7:0] CH_UC_F    = 8'h46;

   // Part modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_KEY   = 2'd1;
   localparam logic [1:0] MODE_VALUE = 2'd2;
   localparam logic [1:0] MODE_DROP  = 2'd3;

   // Escape stages
   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_PCT   = 2'd1;
   localparam logic [1:0] ESC_DIGIT = 2'd2;

   localparam int unsigned MAX_RES = 3;

   // One result beat without its last flag
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       in_value;
      logic       pair_end;
   } res_type;

   // All results caused by one input byte
   typedef struct packed {
      logic [1:0]  cnt;
      res_type [MAX_RES-1:0] res;
   } bundle_type;

   // Parser state plus the bundle being built
   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] stage;
      logic [7:0] held;
      bundle_type bund;
   } work_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LC_A && c <= CH_LC_F) ||
             (c >= CH_UC_A && c <= CH_UC_F);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      begin
         v = 8'd0;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
         end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            v = c - CH_LC_A + 8'd10;
         end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            v = c - CH_UC_A + 8'd10;
         end
         return v[3:0];
      end
   endfunction

   // Append one result, tagged with the current part mode
   function automatic work_type do_push(input work_type w, input logic [7:0] b,
                                        input logic valid, input logic pend);
      work_type r;
      res_type  e;
      begin
         r = w;
         e.out_byte   = b;
         e.byte_valid = valid;
         e.in_value   = (w.mode == MODE_VALUE);
         e.pair_end   = pend;
         case (w.bund.cnt)
            2'd0: begin
               r.bund.res[0] = e;
               r.bund.cnt    = 2'd1;
            end
            2'd1: begin
               r.bund.res[1] = e;
               r.bund.cnt    = 2'd2;
            end
            2'd2: begin
               r.bund.res[2] = e;
               r.bund.cnt    = 2'd3;
            end
            default: begin
               r = w;
            end
         endcase
         return r;
      end
   endfunction

   // Handle one raw byte with no escape pending
   function automatic work_type do_feed(input work_type w, input logic [7:0] c);
      work_type r;
      begin
         r = w;
         if (r.mode == MODE_DROP) begin
            if (c == CH_AMP) begin
               r.mode = MODE_START;
            end
         end else if (c == CH_AMP) begin
            if (r.mode == MODE_KEY || r.mode == MODE_VALUE) begin
               r = do_push(r, 8'd0, 1'b0, 1'b1);
            end
            r.mode = MODE_START;
         end else if (r.mode == MODE_START && c == CH_EQUAL) begin
            r.mode = MODE_DROP;
         end else begin
            if (r.mode == MODE_START) begin
               r.mode = MODE_KEY;
            end
            if (c == CH_EQUAL && r.mode == MODE_KEY) begin
               r.mode = MODE_VALUE;
            end else if (c == CH_PERCENT) begin
               r.stage = ESC_PCT;
            end else begin
               r = do_push(r, (c == CH_PLUS) ? CH_SPACE : c, 1'b1, 1'b0);
            end
         end
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/qssud_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qssud_front: byte parser
// Accepts one raw byte per cycle unless queue_full, tracks part mode and
// escapes, and builds the bundle of up to three results that the byte causes.
// ----------------------------------------------------------------------------
module qssud_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  [7:0]              req_in_byte,
   input  wire                     req_end_of_query,
   input  wire                     queue_full,
   output logic                    push,
   output qssud_pkg::bundle_type   push_bundle
);
   import qssud_pkg::*;

   logic [1:0] mode_ff, mode_in;
   logic [1:0] stage_ff, stage_in;
   logic [7:0] held_ff, held_in;
   logic [1:0] end_stage;
   logic       accept;
   work_type   w;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;

   // Parse the incoming byte against the current state
   always_comb begin
      w.mode      = mode_ff;
      w.stage     = stage_ff;
      w.held      = held_ff;
      w.bund      = '0;
      end_stage   = ESC_NONE;

      if (stage_ff == ESC_PCT) begin
         if (is_hex(req_in_byte)) begin
            w.held  = req_in_byte;
            w.stage = ESC_DIGIT;
         end else begin
            w.stage = ESC_NONE;
            w = do_push(w, CH_PERCENT, 1'b1, 1'b0);
            w = do_feed(w, req_in_byte);
         end
      end else if (stage_ff == ESC_DIGIT) begin
         w.stage = ESC_NONE;
         if (is_hex(req_in_byte)) begin
            w = do_push(w, {hex_val(held_ff), hex_val(req_in_byte)}, 1'b1, 1'b0);
         end else begin
            w = do_push(w, CH_PERCENT, 1'b1, 1'b0);
            w = do_feed(w, held_ff);
            w = do_feed(w, req_in_byte);
         end
      end else begin
         w = do_feed(w, req_in_byte);
      end

      // Flush a pending escape and close the pair at the end of the query
      if (req_end_of_query) begin
         end_stage = w.stage;
         if (end_stage != ESC_NONE) begin
            w.stage = ESC_NONE;
            w = do_push(w, CH_PERCENT, 1'b1, 1'b0);
            if (end_stage == ESC_DIGIT) begin
               w = do_feed(w, w.held);
            end
         end
         if (w.mode == MODE_KEY || w.mode == MODE_VALUE) begin
            case (w.bund.cnt)
               2'd1: w.bund.res[0].pair_end = 1'b1;
               2'd2: w.bund.res[1].pair_end = 1'b1;
               2'd3: w.bund.res[2].pair_end = 1'b1;
               default: w = do_push(w, 8'd0, 1'b0, 1'b1);
            endcase
         end
         w.mode  = MODE_START;
         w.stage = ESC_NONE;
         w.held  = 8'd0;
      end
   end

   assign mode_in     = accept ? w.mode  : mode_ff;
   assign stage_in    = accept ? w.stage : stage_ff;
   assign held_in     = accept ? w.held  : held_ff;
   assign push        = accept && (w.bund.cnt != 2'd0);
   assign push_bundle = w.bund;

   // Advance the parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_START;
         stage_ff <= ESC_NONE;
         held_ff  <= 8'd0;
      end else begin
         mode_ff  <= mode_in;
         stage_ff <= stage_in;
         held_ff  <= held_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/qssud_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qssud_queue: bundle queue
// Short first-in first-out queue of result bundles between parser and
// output sequencer.
// ----------------------------------------------------------------------------
module qssud_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  qssud_pkg::bundle_type   push_bundle,
   input  wire                     pop,
   output qssud_pkg::bundle_type   head,
   output logic                    empty,
   output logic                    full
);
   import qssud_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   bundle_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_FULL);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // Advance pointers with wrap at the last entry
   assign wr_ptr_in = do_push ? ((wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1)
                              : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? ((rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1)
                              : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Store incoming bundle
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/qssud_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qssud_back: output sequencer
// Walks the results of the head bundle one beat at a time and releases the
// bundle after its last beat is taken.
// ----------------------------------------------------------------------------
module qssud_back (
   input  wire                     clock,
   input  wire                     reset,
   input  qssud_pkg::bundle_type   head,
   input  wire                     empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_in_value,
   output logic                    rsp_pair_end,
   output logic                    rsp_last
);
   import qssud_pkg::*;

   logic [1:0] slot_ff, slot_in;
   res_type    cur;
   logic       take;

   // Select the current result of the head bundle
   always_comb begin
      case (slot_ff)
         2'd0:    cur = head.res[0];
         2'd1:    cur = head.res[1];
         2'd2:    cur = head.res[2];
         default: cur = head.res[0];
      endcase
   end

   assign rsp_valid      = ~empty;
   assign rsp_out_byte   = cur.out_byte;
   assign rsp_byte_valid = cur.byte_valid;
   assign rsp_in_value   = cur.in_value;
   assign rsp_pair_end   = cur.pair_end;
   assign rsp_last       = (slot_ff == head.cnt - 2'd1);
   assign take           = ~empty & ~rsp_stall;
   assign pop            = take & rsp_last;

   // Advance to the next beat, back to the first on a bundle's last
   assign slot_in = take ? (rsp_last ? 2'd0 : slot_ff + 2'd1) : slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/query_string_splitter_url_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// query_string_splitter_url_decoder: query string splitter and percent decoder
// Splits a URL query string into key/value pairs and percent-decodes them.
// ----------------------------------------------------------------------------
// Takes one raw byte of a query string per cycle while the queue has room
// and returns its decoded bytes, each tagged key or value, with the end of
// every pair flagged and the final beat of each input byte marked by
// rsp_last. Each input byte causes zero to three result beats; an ordinary
// byte causes one, so while results are not stalled the block sustains one
// byte per cycle, and a malformed escape or the end of the query adds up to
// two extra beats. The parser decides all results of a byte in the cycle it
// is accepted and queues them as one bundle; the output side sends one beat
// per cycle unless stalled, so the single output port sets the long-run rate
// at one result beat per cycle. Up to QUEUE_DEPTH bundles wait between the
// sides; a byte is taken whenever the queue has room, even if results stall.
// ----------------------------------------------------------------------------
module query_string_splitter_url_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_in_byte,
   input  wire        req_end_of_query,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_in_value,
   output logic       rsp_pair_end,
   output logic       rsp_last
);
   import qssud_pkg::*;

   logic       push;
   logic       pop;
   logic       empty;
   logic       full;
   bundle_type push_bundle;
   bundle_type head;

   // Parse incoming bytes
   qssud_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_query (req_end_of_query),
      .queue_full       (full),
      .push             (push),
      .push_bundle      (push_bundle)
   );

   // Hold bundles between the two sides
   qssud_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .empty       (empty),
      .full        (full)
   );

   // Send results one beat at a time
   qssud_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_in_value   (rsp_in_value),
      .rsp_pair_end   (rsp_pair_end),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire
